>>> design/imfr_pkg.sv
// ----------------------------------------------------------------------------
// IMAP message length framer package
// Shared widths, character codes, the brace pattern type and the record that
// carries one classified byte from the front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package imfr_pkg;

  // Width of the internal length counters and of the reported length.
  localparam int LENGTH_BITS = 20;
  localparam int MSG_LEN_W   = 20;
  localparam int LIT_WIDE_W  = LENGTH_BITS + 4;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  // Characters that the framer reacts to.
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_OPEN  = 8'h7B;
  localparam logic [7:0] CH_CLOSE = 8'h7D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Line length tracking saturates at the top of a 3-bit count.
  localparam int              SEG_W            = 3;
  localparam logic [SEG_W-1:0] SEG_MAX         = '1;
  localparam int              MIN_LITERAL_LINE = 5;
  // Bytes before the line feed that a literal announcement needs.
  localparam logic [SEG_W-1:0] SEG_LITERAL_MIN = SEG_W'(MIN_LITERAL_LINE - 1);

  // Progress through the '{' digits '}' CR ending of a line.
  typedef enum logic [1:0] {
    PAT_NONE     = 2'd0,
    PAT_DIGITS   = 2'd1,
    PAT_CLOSE    = 2'd2,
    PAT_CLOSE_CR = 2'd3
  } brace_pat_t;

  // One byte after classification.
  typedef struct packed {
    logic       is_lf;
    logic       is_cr;
    logic       is_open;
    logic       is_close;
    logic       is_digit;
    logic [3:0] digit;
    logic       last;
  } byte_class_t;

endpackage

`default_nettype wire

>>> design/imfr_in_if.sv
// ----------------------------------------------------------------------------
// IMAP framer byte channel
// Valid/ready channel that carries one buffer byte and its last-byte mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface imfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

>>> design/imfr_out_if.sv
// ----------------------------------------------------------------------------
// IMAP framer result channel
// Valid/ready channel that carries the found flag and the message length.
// ----------------------------------------------------------------------------
`default_nettype none

interface imfr_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [19:0] msg_length;

  modport source (output valid, output found, output msg_length, input ready);
  modport sink   (input valid, input found, input msg_length, output ready);
endinterface

`default_nettype wire

>>> design/imap_message_length_framer_core.sv
// ----------------------------------------------------------------------------
// IMAP message length framer
// Finds the length of the first complete IMAP message in a byte buffer.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one buffer byte per item with a mark on the final byte.
//   out_chan carries at most one item per buffer: found with the message
//   length including its CR LF, or not-found with length zero on the last
//   byte. cfg_wr_en with cfg_wr_data sets client mode, which enables literal
//   {n} detection; write it only while the block is idle.
//   Throughput is one byte per cycle while out_chan does not stall. A byte
//   waits in the two-entry front queue, then the back end's state update
//   writes its result into the output register, from which it is offered.
//   If out_chan stalls, the result waits in the output register and the
//   front queue keeps taking bytes until both of its entries are full, then
//   in_chan.ready drops.
//   Reset (synchronous, active low) empties the queue and the output
//   register, clears the buffer state and selects server mode.
// ----------------------------------------------------------------------------
`default_nettype none

module imap_message_length_framer_core (
  input  wire logic clk,
  input  wire logic rst_n,
  imfr_in_if.sink   in_chan,
  imfr_out_if.source out_chan,
  input  wire logic cfg_wr_en,
  input  wire logic cfg_wr_data
);

  logic                  client_side_r;
  logic                  q_valid;
  logic                  q_pop;
  imfr_pkg::byte_class_t q_item;

  // Mode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      client_side_r <= 1'b0;
    end else if (cfg_wr_en) begin
      client_side_r <= cfg_wr_data;
    end
  end

  imfr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  imfr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .client_side (client_side_r),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_chan    (out_chan)
  );

`ifndef NO_ASSERTIONS
  // The back end never takes from an empty queue.
  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // Back pressure on the input only when the queue holds items.
  a_full_has_items: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> q_valid)
    else $error("input stalled with an empty queue");

  // A new result appears only after a byte left the queue.
  a_result_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(q_pop))
    else $error("result without a processed item");

  // A not-found result always reports length zero.
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.found) |-> (out_chan.msg_length == '0))
    else $error("not-found result with nonzero length");
`endif

endmodule

`default_nettype wire

>>> design/imfr_front.sv
// ----------------------------------------------------------------------------
// IMAP framer front end
// Accepts bytes, classifies them and holds them in a two-entry queue for
// the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module imfr_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  imfr_in_if.sink                    in_chan,
  output      logic                  q_valid,
  output      imfr_pkg::byte_class_t q_item,
  input  wire logic                  q_pop
);

  imfr_pkg::byte_class_t entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       push;
  imfr_pkg::byte_class_t cls;

  // Classify the incoming byte.
  always_comb begin
    cls.is_lf    = (in_chan.data_byte == imfr_pkg::CH_LF);
    cls.is_cr    = (in_chan.data_byte == imfr_pkg::CH_CR);
    cls.is_open  = (in_chan.data_byte == imfr_pkg::CH_OPEN);
    cls.is_close = (in_chan.data_byte == imfr_pkg::CH_CLOSE);
    cls.is_digit = (in_chan.data_byte >= imfr_pkg::CH_ZERO) &&
                   (in_chan.data_byte <= imfr_pkg::CH_NINE);
    cls.digit    = 4'(in_chan.data_byte - imfr_pkg::CH_ZERO);
    cls.last     = in_chan.last_byte;
  end

  // The queue takes an item whenever an entry is free.
  assign in_chan.ready = (count_r != 2'd2);
  assign push          = in_chan.valid && in_chan.ready;
  assign q_valid       = (count_r != 2'd0);
  assign q_item        = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= cls;
    end
  end

endmodule

`default_nettype wire

>>> design/imfr_back.sv
// ----------------------------------------------------------------------------
// IMAP framer back end
// Runs the per-buffer framing state on each classified byte and holds the
// result item in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module imfr_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  client_side,
  input  wire logic                  q_valid,
  input  wire imfr_pkg::byte_class_t q_item,
  output      logic                  q_pop,
  imfr_out_if.source                 out_chan
);

  localparam int LB = imfr_pkg::LENGTH_BITS;
  localparam int LW = imfr_pkg::LIT_WIDE_W;

  logic                       prev_cr_r, prev_cr_nxt;
  logic [imfr_pkg::SEG_W-1:0] seg_r, seg_nxt;
  imfr_pkg::brace_pat_t       pat_r, pat_nxt;
  logic [LB-1:0]              lit_r, lit_nxt;
  logic [LB-1:0]              left_r, left_nxt;
  logic [LB-1:0]              total_r, total_nxt;
  logic                       done_r, done_nxt;

  logic                       out_valid_r;
  logic                       out_found_r;
  logic [imfr_pkg::MSG_LEN_W-1:0] out_len_r;

  logic                       emit;
  logic                       emit_found;
  logic [imfr_pkg::MSG_LEN_W-1:0] emit_len;
  logic [LW-1:0]              lit_wide;
  logic [31:0]                total_wide;

  // A byte leaves the queue when the output register is free or drains now.
  assign q_pop = q_valid && (!out_valid_r || out_chan.ready);

  // Decimal count step: lit * 10 + digit, saturated.
  assign lit_wide = (LW'(lit_r) << 3) + (LW'(lit_r) << 1) + LW'(q_item.digit);

  always_comb begin
    prev_cr_nxt = prev_cr_r;
    seg_nxt     = seg_r;
    pat_nxt     = pat_r;
    lit_nxt     = lit_r;
    left_nxt    = left_r;
    total_nxt   = total_r;
    done_nxt    = done_r;
    emit        = 1'b0;
    emit_found  = 1'b0;
    emit_len    = '0;
    total_wide  = 32'(total_r);

    if (q_pop) begin
      if (!done_r) begin
        if (total_r != imfr_pkg::LEN_MAX) begin
          total_nxt = total_r + LB'(1);
        end
        total_wide = 32'(total_nxt);

        priority if (left_r != '0) begin
          // Literal bytes are counted and not searched.
          left_nxt = left_r - LB'(1);
        end else if (q_item.is_lf) begin
          if (prev_cr_r) begin
            if (client_side && (pat_r == imfr_pkg::PAT_CLOSE_CR) &&
                (seg_r >= imfr_pkg::SEG_LITERAL_MIN)) begin
              left_nxt = lit_r;
            end else begin
              done_nxt   = 1'b1;
              emit       = 1'b1;
              emit_found = 1'b1;
              emit_len   = total_wide[imfr_pkg::MSG_LEN_W-1:0];
            end
          end
          seg_nxt = '0;
          pat_nxt = imfr_pkg::PAT_NONE;
          lit_nxt = '0;
        end else begin
          // Ordinary line byte: track the brace ending of the line.
          if (seg_r != imfr_pkg::SEG_MAX) begin
            seg_nxt = seg_r + imfr_pkg::SEG_W'(1);
          end
          priority if (q_item.is_open) begin
            pat_nxt = imfr_pkg::PAT_DIGITS;
            lit_nxt = '0;
          end else if ((pat_r == imfr_pkg::PAT_DIGITS) && q_item.is_digit) begin
            lit_nxt = (lit_wide > LW'(imfr_pkg::LEN_MAX)) ? imfr_pkg::LEN_MAX
                                                          : lit_wide[LB-1:0];
          end else if ((pat_r == imfr_pkg::PAT_DIGITS) && q_item.is_close) begin
            pat_nxt = imfr_pkg::PAT_CLOSE;
          end else if ((pat_r == imfr_pkg::PAT_CLOSE) && q_item.is_cr) begin
            pat_nxt = imfr_pkg::PAT_CLOSE_CR;
          end else begin
            pat_nxt = imfr_pkg::PAT_NONE;
          end
        end
        prev_cr_nxt = q_item.is_cr;
      end

      // The last byte reports not-found if needed and clears the buffer state.
      if (q_item.last) begin
        if (!done_nxt) begin
          emit       = 1'b1;
          emit_found = 1'b0;
          emit_len   = '0;
        end
        prev_cr_nxt = 1'b0;
        seg_nxt     = '0;
        pat_nxt     = imfr_pkg::PAT_NONE;
        lit_nxt     = '0;
        left_nxt    = '0;
        total_nxt   = '0;
        done_nxt    = 1'b0;
      end
    end
  end

  // Framing state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_cr_r <= 1'b0;
      seg_r     <= '0;
      pat_r     <= imfr_pkg::PAT_NONE;
      lit_r     <= '0;
      left_r    <= '0;
      total_r   <= '0;
      done_r    <= 1'b0;
    end else begin
      prev_cr_r <= prev_cr_nxt;
      seg_r     <= seg_nxt;
      pat_r     <= pat_nxt;
      lit_r     <= lit_nxt;
      left_r    <= left_nxt;
      total_r   <= total_nxt;
      done_r    <= done_nxt;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= emit;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      out_found_r <= emit_found;
      out_len_r   <= emit_len;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.found      = out_found_r;
  assign out_chan.msg_length = out_len_r;

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IMAP message length framer testbench
// Feeds byte buffers into the framer through its valid/ready byte channel and
// checks every result item against an in-bench prediction of the first message
// length. Directed buffers hit the corner cases, then random buffers made of
// plain lines, literal announcements, cut-off literals, unterminated lines and
// noise run in both modes under varying back-pressure.
// ----------------------------------------------------------------------------

module testbench;
  import imfr_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 20000;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } buffer_byte_t;

  typedef struct {
    logic                 found;
    logic [MSG_LEN_W-1:0] length;
  } framing_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;

  imfr_in_if  in_if ();
  imfr_out_if out_if ();

  imap_message_length_framer_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_if),
    .out_chan    (out_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Items waiting to be sent, results still owed by the block.
  buffer_byte_t    pending_bytes[$];
  framing_result_t expected_lengths[$];
  logic [7:0]      frame_q[$];

  int unsigned sender_idle_pct = 17;
  int unsigned receiver_idle_pct = 60;
  int          bytes_queued = 0;
  int          error_count = 0;
  logic        in_fire = 1'b0;

  // Predicted framer state, mirrored from the block's buffer state.
  logic                   pr_client = 1'b0;
  logic [7:0]             pr_prev = '0;
  logic [SEG_W-1:0]       pr_seg = '0;
  brace_pat_t             pr_pat = PAT_NONE;
  logic [LENGTH_BITS-1:0] pr_lit_count = '0;
  logic [LENGTH_BITS-1:0] pr_lit_left = '0;
  logic [LENGTH_BITS-1:0] pr_total = '0;
  logic                   pr_done = 1'b0;

  function automatic void clear_framing();
    pr_prev = '0;
    pr_seg = '0;
    pr_pat = PAT_NONE;
    pr_lit_count = '0;
    pr_lit_left = '0;
    pr_total = '0;
    pr_done = 1'b0;
  endfunction

  // Advances the predicted state by one byte and queues any result it causes.
  function automatic void frame_byte(input logic [7:0] b, input logic last);
    logic [63:0] wide;
    if (!pr_done) begin
      if (pr_total != LEN_MAX) pr_total = pr_total + 1'b1;
      if (pr_lit_left != '0) begin
        pr_lit_left = pr_lit_left - 1'b1;
      end else if (b == CH_LF) begin
        if (pr_prev == CH_CR) begin
          // A long enough line ending in {n} CR LF opens a literal in client mode.
          if (pr_client && pr_pat == PAT_CLOSE_CR && pr_seg >= SEG_LITERAL_MIN) begin
            pr_lit_left = pr_lit_count;
          end else begin
            pr_done = 1'b1;
            expected_lengths.push_back('{1'b1, MSG_LEN_W'(pr_total)});
          end
        end
        pr_seg = '0;
        pr_pat = PAT_NONE;
        pr_lit_count = '0;
      end else begin
        if (pr_seg != SEG_MAX) pr_seg = pr_seg + 1'b1;
        if (b == CH_OPEN) begin
          pr_pat = PAT_DIGITS;
          pr_lit_count = '0;
        end else if (pr_pat == PAT_DIGITS && b >= CH_ZERO && b <= CH_NINE) begin
          wide = 64'(pr_lit_count) * 64'd10 + 64'(b - CH_ZERO);
          pr_lit_count = (wide > 64'(LEN_MAX)) ? LEN_MAX : wide[LENGTH_BITS-1:0];
        end else if (pr_pat == PAT_DIGITS && b == CH_CLOSE) begin
          pr_pat = PAT_CLOSE;
        end else if (pr_pat == PAT_CLOSE && b == CH_CR) begin
          pr_pat = PAT_CLOSE_CR;
        end else begin
          pr_pat = PAT_NONE;
        end
      end
      pr_prev = b;
    end
    if (last) begin
      if (!pr_done) expected_lengths.push_back('{1'b0, '0});
      clear_framing();
    end
  endfunction

  // Monitor: tracks register writes, predicts on accepted bytes, checks results.
  always @(posedge clk) begin : monitor
    framing_result_t want;
    in_fire = rst_n && in_if.valid && in_if.ready;
    if (rst_n) begin
      if (cfg_wr_en) pr_client = cfg_wr_data;
      if (in_fire) frame_byte(in_if.data_byte, in_if.last_byte);
      if (out_if.valid && out_if.ready) begin
        if (expected_lengths.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result item: found=%0b length=%0d", $time,
                   out_if.found, out_if.msg_length);
        end else begin
          want = expected_lengths.pop_front();
          if (out_if.found !== want.found) begin
            error_count++;
            $display("%0t: found mismatch: expected %0b, actual %0b", $time,
                     want.found, out_if.found);
          end
          if (out_if.msg_length !== want.length) begin
            error_count++;
            $display("%0t: msg_length mismatch: expected %0d, actual %0d", $time,
                     want.length, out_if.msg_length);
          end
        end
      end
    end
  end

  // Driver: presents pending bytes and drives result back-pressure.
  always @(negedge clk) begin : driver
    buffer_byte_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      out_if.ready <= 1'b0;
    end else begin
      if (!in_if.valid || in_fire) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          nxt = pending_bytes.pop_front();
          in_if.valid <= 1'b1;
          in_if.data_byte <= nxt.data;
          in_if.last_byte <= nxt.last;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      out_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // Buffer building helpers.
  function automatic void put_byte(input logic [7:0] b);
    frame_q.push_back(b);
  endfunction

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
  endfunction

  function automatic void put_crlf();
    frame_q.push_back(CH_CR);
    frame_q.push_back(CH_LF);
  endfunction

  // Line content: mostly printable text, sometimes any byte but a line feed.
  function automatic void put_line(input int n);
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 6) begin
        c = 8'($urandom_range(8'h7E, 8'h20));
      end else begin
        do c = 8'($urandom_range(255)); while (c == CH_LF);
      end
      frame_q.push_back(c);
    end
  endfunction

  // Raw bytes, biased toward the characters the framer reacts to.
  function automatic void put_any(input int n);
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(7))
        0: c = CH_CR;
        1: c = CH_LF;
        2: c = CH_OPEN;
        3: c = CH_CLOSE;
        4: c = 8'($urandom_range(CH_NINE, CH_ZERO));
        default: c = 8'($urandom_range(255));
      endcase
      frame_q.push_back(c);
    end
  endfunction

  // Literal announcement; a zero count is sometimes written as empty braces.
  function automatic void put_announce(input longint unsigned n);
    put_byte(CH_OPEN);
    if (n != 0 || $urandom_range(1)) put_text($sformatf("%0d", n));
    put_byte(CH_CLOSE);
    put_crlf();
  endfunction

  // Moves the built buffer into the send queue, marking its final byte.
  function automatic void send_frame();
    if (frame_q.size() == 0) frame_q.push_back(8'($urandom_range(255)));
    foreach (frame_q[i]) pending_bytes.push_back('{frame_q[i], i == frame_q.size() - 1});
    bytes_queued += frame_q.size();
    frame_q.delete();
  endfunction

  function automatic void gen_random_buffer();
    int unsigned    kind;
    longint unsigned n;
    if ($urandom_range(9) == 0) put_byte(CH_LF);
    kind = $urandom_range(99);
    if (kind < 35) begin
      // Plain command line followed by bytes that must be ignored.
      put_line($urandom_range(10));
      put_crlf();
      put_any($urandom_range(4));
    end else if (kind < 65) begin
      // One or two literals, then the rest of the command.
      repeat ($urandom_range(2, 1)) begin
        put_line($urandom_range(6));
        case ($urandom_range(9))
          0, 1:    n = 0;
          2:       n = $urandom_range(200, 13);
          default: n = $urandom_range(12, 1);
        endcase
        put_announce(n);
        put_any(int'(n));
      end
      put_line($urandom_range(6));
      put_crlf();
      put_any($urandom_range(4));
    end else if (kind < 75) begin
      // Literal cut off by the end of the buffer, possibly with a huge count.
      put_line($urandom_range(6));
      case ($urandom_range(3))
        0: n = 64'd99999999999;
        1: n = 64'(LEN_MAX) + $urandom_range(1);
        default: n = $urandom_range(8);
      endcase
      put_announce(n);
      put_any((n > 8) ? $urandom_range(8) : $urandom_range(int'(n)));
    end else if (kind < 87) begin
      // Line that never ends.
      put_line($urandom_range(12, 1));
    end else begin
      put_any($urandom_range(16, 1));
    end
    send_frame();
  endfunction

  task automatic wait_drained();
    int guard;
    guard = 0;
    while ((pending_bytes.size() != 0 || in_if.valid || expected_lengths.size() != 0)
           && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_client_side(input logic value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_random(input int target);
    int start;
    start = bytes_queued;
    while (bytes_queued - start < target) gen_random_buffer();
  endtask

  // Stimulus sequence.
  initial begin
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.last_byte = 1'b0;
    out_if.ready = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed buffers in client mode.
    write_client_side(1'b1);
    // Line feed first, then the extreme byte values in a short message.
    put_byte(CH_LF);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_crlf();
    send_frame();
    // Empty count literal, then the real end.
    put_text("ab{}");
    put_crlf();
    put_crlf();
    send_frame();
    // Announcement on a line too short to open a literal.
    put_text("{}");
    put_crlf();
    send_frame();
    // Buffer ending exactly at the end of a literal.
    put_text("x{1}");
    put_crlf();
    put_text("Z");
    send_frame();
    wait_drained();

    run_random(330);
    wait_drained();

    sender_idle_pct = 60;
    receiver_idle_pct = 17;
    write_client_side(1'b0);
    run_random(300);
    wait_drained();

    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    write_client_side(1'b1);
    run_random(330);
    wait_drained();

    repeat (20) @(posedge clk);
    if (expected_lengths.size() != 0) begin
      error_count++;
      $display("%0t: %0d expected result items never arrived", $time,
               expected_lengths.size());
    end
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> sim.f
design/imfr_pkg.sv
design/imfr_in_if.sv
design/imfr_out_if.sv
design/imfr_front.sv
design/imfr_back.sv
design/imap_message_length_framer_core.sv
tb/sv/testbench.sv
